FILE: rtl/core/polyac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polyac_pkg
// Shared constants and controller/datapath handshake types for the polygon
// area and clearance block.
// ----------------------------------------------------------------------------
package polyac_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_WIDTH_DEF  = 16;

    localparam int AREA_W  = 35;
    localparam int CLR_W   = 17;
    localparam int CNT_W   = 5;
    localparam int D2_W    = 40;
    localparam int CNT_MAX = 31;

    localparam int SHORT_EDGE_LIMIT = 6;   // 0.0001 in Q16.16
    localparam int DIV_STEPS        = 16;
    localparam int SQRT_STEPS       = 20;
    localparam int STEP_W           = 5;

    // datapath commands issued by the sequencer
    typedef struct packed {
        logic load;
        logic first;
        logic sel_close;
        logic ops;
        logic mul;
        logic sum;
        logic dec;
        logic div_step;
        logic proj;
        logic rnd;
        logic sq;
        logic sqsum;
        logic min_upd;
        logic commit;
        logic sqrt_init;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic cnt_ge3;
        logic last;
        logic need_div;
        logic res_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/core/polyac_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polyac_datapath
// Vertex registers, shoelace accumulator, per-edge distance unit with a
// restoring divider, integer square root and result register.
// ----------------------------------------------------------------------------
module polyac_datapath import polyac_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cmd                          i_cmd,
    output t_sts                               o_sts,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_y,
    input  wire logic                          i_last_vertex,
    input  wire logic                          i_res_stall,
    output logic                               o_res_valid,
    output logic [AREA_W-1:0]                  o_area,
    output logic [CLR_W-1:0]                   o_clearance,
    output logic                               o_valid_res,
    output logic [CNT_W-1:0]                   o_vertex_count
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 1;
    localparam int QW  = DW + 17;
    localparam int EXW = DW + 18;
    localparam int ERW = EXW - 16;
    localparam int XW  = 2 * ERW + 1;
    localparam int CW  = (XW > D2_W) ? XW : D2_W;
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int AW  = SW + NW + 1;
    localparam int HW  = (AW > AREA_W + 1) ? AW : AREA_W + 1;
    localparam int RW  = D2_W + 1;

    localparam logic [D2_W-1:0]   D2_MAX   = '1;
    localparam logic [AREA_W-1:0] AREA_MAX = '1;
    localparam logic [CLR_W-1:0]  CLR_MAX  = '1;

    logic signed [W-1:0]  r_in_x, r_in_y, r_in_cx, r_in_cy;
    logic                 r_in_last;
    logic signed [W-1:0]  r_fx, r_fy, r_px, r_py, r_cx, r_cy;
    logic signed [AW-1:0] r_acc;
    logic [D2_W-1:0]      r_min;
    logic [NW-1:0]        r_cnt;

    logic signed [W-1:0]  r_ax, r_ay, r_bx, r_by;
    logic signed [DW-1:0] r_dx, r_dy, r_wx, r_wy, r_ux, r_uy;
    logic signed [PW-1:0] r_pa, r_pb, r_mdx, r_mdy, r_mwx, r_mwy, r_mux, r_muy;
    logic signed [PW-1:0] r_mt1, r_mt2;
    logic signed [SW-1:0] r_len2, r_ws, r_es, r_dot;
    logic [SW:0]          r_rem;
    logic [DIV_STEPS-1:0] r_t;
    logic signed [QW-1:0] r_qx, r_qy;
    logic [ERW-1:0]       r_ex, r_ey;
    logic [2*ERW-1:0]     r_sx, r_sy;
    logic [CW-1:0]        r_d2;
    logic [RW-1:0]        r_sv, r_sr, r_sb;
    logic                 r_res_valid;
    logic [AREA_W-1:0]    r_area;
    logic [CLR_W-1:0]     r_clr;
    logic                 r_vres;
    logic [CNT_W-1:0]     r_vcnt;

    logic signed [W-1:0]   bx, by;
    logic                  short_edge, dot_le0, dot_ge;
    logic [SW:0]           rem2, len2_u;
    logic [EXW-1:0]        rnd_x, rnd_y;
    logic [RW-1:0]         trial;
    logic [D2_W-1:0]       d2_sat;
    logic [AW-1:0]         acc_mag;
    logic [HW-1:0]         half;
    logic [RW-1:0]         clr_full;
    logic [7:0]            cnt8;
    logic                  ge3;

    function automatic logic [EXW-1:0] round_mag(input logic signed [QW-1:0] q,
                                                 input logic signed [DW-1:0] w);
        logic signed [EXW-1:0] e;
        logic [EXW-1:0]        m;
        e = EXW'(q) - (EXW'(w) <<< 16);
        m = e[EXW-1] ? EXW'(-e) : EXW'(e);
        return m + EXW'(32768);
    endfunction

    assign bx = i_cmd.sel_close ? r_fx : r_in_x;
    assign by = i_cmd.sel_close ? r_fy : r_in_y;

    assign short_edge = r_len2 <= SW'(SHORT_EDGE_LIMIT);
    assign dot_le0    = r_dot[SW-1] || (r_dot == '0);
    assign dot_ge     = r_dot >= r_len2;
    assign len2_u     = (SW+1)'($unsigned(r_len2));
    assign rem2       = {r_rem[SW-1:0], 1'b0};
    assign rnd_x      = round_mag(r_qx, r_wx);
    assign rnd_y      = round_mag(r_qy, r_wy);
    assign trial      = r_sr + r_sb;
    assign d2_sat     = (r_d2 > CW'(D2_MAX)) ? D2_MAX : r_d2[D2_W-1:0];
    assign acc_mag    = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
    assign half       = (HW'(acc_mag) + HW'(1)) >> 1;
    assign clr_full   = (r_sv > r_sr) ? r_sr + RW'(1) : r_sr;
    assign cnt8       = 8'(r_cnt);
    assign ge3        = r_cnt >= NW'(3);

    assign o_sts.cnt_zero = r_cnt == '0;
    assign o_sts.cnt_full = r_cnt >= NW'(MAX_VERTICES);
    assign o_sts.cnt_ge3  = ge3;
    assign o_sts.last     = r_in_last;
    assign o_sts.need_div = !short_edge && !dot_le0 && !dot_ge;
    assign o_sts.res_free = !r_res_valid || !i_res_stall;

    // input capture and edge arithmetic (no reset needed)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_x    <= i_vertex_x;
            r_in_y    <= i_vertex_y;
            r_in_cx   <= i_center_x;
            r_in_cy   <= i_center_y;
            r_in_last <= i_last_vertex;
        end
        if (i_cmd.ops) begin
            r_ax <= r_px;
            r_ay <= r_py;
            r_bx <= bx;
            r_by <= by;
            r_dx <= DW'(bx) - DW'(r_px);
            r_dy <= DW'(by) - DW'(r_py);
            r_wx <= DW'(r_cx) - DW'(r_px);
            r_wy <= DW'(r_cy) - DW'(r_py);
            r_ux <= DW'(r_cx) - DW'(bx);
            r_uy <= DW'(r_cy) - DW'(by);
        end
        if (i_cmd.mul) begin
            r_pa  <= r_ax * r_by;
            r_pb  <= r_bx * r_ay;
            r_mdx <= r_dx * r_dx;
            r_mdy <= r_dy * r_dy;
            r_mwx <= r_wx * r_wx;
            r_mwy <= r_wy * r_wy;
            r_mux <= r_ux * r_ux;
            r_muy <= r_uy * r_uy;
            r_mt1 <= r_wx * r_dx;
            r_mt2 <= r_wy * r_dy;
        end
        if (i_cmd.sum) begin
            r_len2 <= SW'(r_mdx) + SW'(r_mdy);
            r_ws   <= SW'(r_mwx) + SW'(r_mwy);
            r_es   <= SW'(r_mux) + SW'(r_muy);
            r_dot  <= SW'(r_mt1) + SW'(r_mt2);
        end
        if (i_cmd.dec) begin
            r_rem <= (SW+1)'($unsigned(r_dot));
            r_t   <= '0;
            if (short_edge || dot_le0) begin
                r_d2 <= CW'($unsigned(r_ws));
            end else begin
                r_d2 <= CW'($unsigned(r_es));
            end
        end
        if (i_cmd.div_step) begin
            if (rem2 >= len2_u) begin
                r_rem <= rem2 - len2_u;
                r_t   <= {r_t[DIV_STEPS-2:0], 1'b1};
            end else begin
                r_rem <= rem2;
                r_t   <= {r_t[DIV_STEPS-2:0], 1'b0};
            end
        end
        if (i_cmd.proj) begin
            r_qx <= r_dx * $signed({1'b0, r_t});
            r_qy <= r_dy * $signed({1'b0, r_t});
        end
        if (i_cmd.rnd) begin
            r_ex <= rnd_x[EXW-1:16];
            r_ey <= rnd_y[EXW-1:16];
        end
        if (i_cmd.sq) begin
            r_sx <= r_ex * r_ex;
            r_sy <= r_ey * r_ey;
        end
        if (i_cmd.sqsum) begin
            r_d2 <= CW'(r_sx) + CW'(r_sy);
        end
        if (i_cmd.sqrt_init) begin
            r_sv <= RW'(r_min);
            r_sr <= '0;
            r_sb <= RW'(1) << (2 * (SQRT_STEPS - 1));
        end
        if (i_cmd.sqrt_step) begin
            if (r_sv >= trial) begin
                r_sv <= r_sv - trial;
                r_sr <= (r_sr >> 1) + r_sb;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_sb <= r_sb >> 2;
        end
        if (i_cmd.out_load) begin
            if (ge3) begin
                r_area <= (half > HW'(AREA_MAX)) ? AREA_MAX : half[AREA_W-1:0];
                r_clr  <= (clr_full > RW'(CLR_MAX)) ? CLR_MAX : clr_full[CLR_W-1:0];
                r_vres <= 1'b1;
            end else begin
                r_area <= '0;
                r_clr  <= '0;
                r_vres <= 1'b0;
            end
            r_vcnt <= (cnt8 > 8'(CNT_MAX)) ? CNT_W'(CNT_MAX) : cnt8[CNT_W-1:0];
        end
    end

    // polygon state, cleared after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_fx  <= '0;
            r_fy  <= '0;
            r_px  <= '0;
            r_py  <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
            r_acc <= '0;
            r_min <= D2_MAX;
            r_cnt <= '0;
        end else begin
            if (i_cmd.first) begin
                r_fx  <= r_in_x;
                r_fy  <= r_in_y;
                r_px  <= r_in_x;
                r_py  <= r_in_y;
                r_cx  <= r_in_cx;
                r_cy  <= r_in_cy;
                r_cnt <= r_cnt + NW'(1);
            end
            if (i_cmd.sum) begin
                r_acc <= r_acc + AW'(r_pa) - AW'(r_pb);
            end
            if (i_cmd.min_upd && (d2_sat < r_min)) begin
                r_min <= d2_sat;
            end
            if (i_cmd.commit) begin
                r_px  <= r_in_x;
                r_py  <= r_in_y;
                r_cnt <= r_cnt + NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_area         = r_area;
    assign o_clearance    = r_clr;
    assign o_valid_res    = r_vres;
    assign o_vertex_count = r_vcnt;

endmodule
`default_nettype wire

FILE: rtl/core/polyac_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polyac_ctrl
// Sequencer: per-vertex edge pass, polygon close, square root and result.
// ----------------------------------------------------------------------------
module polyac_ctrl import polyac_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_vertex_valid,
    output logic      o_vertex_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_CHK  = 15'b000000000000010,
        S_OPS  = 15'b000000000000100,
        S_MUL  = 15'b000000000001000,
        S_SUM  = 15'b000000000010000,
        S_DEC  = 15'b000000000100000,
        S_DIV  = 15'b000000001000000,
        S_PROJ = 15'b000000010000000,
        S_RND  = 15'b000000100000000,
        S_SQ   = 15'b000001000000000,
        S_SQS  = 15'b000010000000000,
        S_MIN  = 15'b000100000000000,
        S_LAST = 15'b001000000000000,
        S_SQRT = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } t_state;

    t_state            r_state, n_state;
    logic              r_close, n_close;
    logic [STEP_W-1:0] r_step, n_step;

    assign o_vertex_stall = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        n_close = r_close;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.sel_close = r_close;
        unique case (r_state)
            S_IDLE: begin
                if (i_vertex_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                n_close = 1'b0;
                if (i_sts.cnt_full) begin
                    n_state = S_LAST;
                end else if (i_sts.cnt_zero) begin
                    o_cmd.first = 1'b1;
                    n_state     = S_LAST;
                end else begin
                    n_state = S_OPS;
                end
            end
            S_OPS: begin
                o_cmd.ops = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DEC;
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                n_step    = '0;
                n_state   = i_sts.need_div ? S_DIV : S_MIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_PROJ;
                end
            end
            S_PROJ: begin
                o_cmd.proj = 1'b1;
                n_state    = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_SQS;
            end
            S_SQS: begin
                o_cmd.sqsum = 1'b1;
                n_state     = S_MIN;
            end
            S_MIN: begin
                o_cmd.min_upd = 1'b1;
                if (r_close) begin
                    // root setup reads the minimum, so it starts once r_min is registered
                    n_step  = '0;
                    n_state = S_SQRT;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_LAST;
                end
            end
            S_LAST: begin
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (i_sts.cnt_ge3) begin
                    n_close = 1'b1;
                    n_state = S_OPS;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SQRT: begin
                if (r_step == '0) begin
                    o_cmd.sqrt_init = 1'b1;
                end else begin
                    o_cmd.sqrt_step = 1'b1;
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SQRT_STEPS)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.res_free) begin
                    o_cmd.out_load = 1'b1;
                    n_close        = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_close <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_close <= n_close;
            r_step  <= n_step;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/polygon_area_and_clearance_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_area_and_clearance_top
// Polygon area and center clearance, one vertex per beat.
// ----------------------------------------------------------------------------
// Input channel: i_vertex_valid / o_vertex_stall carries one vertex per beat,
// Q8.8 coordinates; the center is sampled on a polygon's first vertex and
// i_last_vertex closes the polygon. Output channel: o_res_valid /
// i_res_stall carries one result beat per closed polygon.
// Throughput is set by the sequencer, one vertex at a time: a first or
// dropped vertex only passes the check and last-vertex states; an edge runs
// the operand, multiply, sum, decide and minimum states, plus the 16-step
// restoring divider, projection, rounding and squaring when the projection
// is needed. Closing adds one more edge, the square root and a result load.
// Vertices beyond MAX_VERTICES are dropped and not counted, but a dropped last vertex still closes the polygon.
// Reset clears the polygon state and the result valid flag; no clearing pass.
// A stalled result holds its payload; the next polygon streams in behind it
// and only waits at its own result if the previous one is still held.
// ----------------------------------------------------------------------------
module polygon_area_and_clearance_top import polyac_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vertex_valid,
    output logic                               o_vertex_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_y,
    input  wire logic                          i_last_vertex,
    output logic                               o_res_valid,
    input  wire logic                          i_res_stall,
    output logic [AREA_W-1:0]                  o_area,
    output logic [CLR_W-1:0]                   o_clearance,
    output logic                               o_valid_res,
    output logic [CNT_W-1:0]                   o_vertex_count
);

    t_cmd cmd;
    t_sts sts;

    polyac_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_valid (i_vertex_valid),
        .o_vertex_stall (o_vertex_stall),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    polyac_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_last_vertex  (i_last_vertex),
        .i_res_stall    (i_res_stall),
        .o_res_valid    (o_res_valid),
        .o_area         (o_area),
        .o_clearance    (o_clearance),
        .o_valid_res    (o_valid_res),
        .o_vertex_count (o_vertex_count)
    );

endmodule
`default_nettype wire
